// File: sv/key_min_hold_release_scheduler_defines.svh
// Assertion macros used by the checks in the scheduler top level.
`ifndef KEY_MIN_HOLD_RELEASE_SCHEDULER_DEFINES_SVH
`define KEY_MIN_HOLD_RELEASE_SCHEDULER_DEFINES_SVH

// Checked on every edge outside reset.
`define KMHR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define KMHR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/kmhr_pkg.sv
`timescale 1ns / 1ps

package kmhr_pkg;

   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = 5;   // enough for 16 buttons and 2 sticks
   localparam int RSP_MAX  = 10;  // results kept per item
   localparam int CNT_W    = 4;   // holds 0..RSP_MAX
   localparam int Q_W      = 4;   // indexes 0..RSP_MAX-1

   localparam logic [TIME_W-1:0] MIN_HOLD_RESET = 32'd16600;
   localparam logic [3:0]        STICK_ID_BASE  = 4'd8;

   // Register index of min_hold_time on the APB port.
   localparam logic REG_MIN_HOLD = 1'b0;

   // Action codes.
   localparam logic [2:0] ACT_BTN_PRESS   = 3'd0;
   localparam logic [2:0] ACT_BTN_RELEASE = 3'd1;
   localparam logic [2:0] ACT_STK_PRESS   = 3'd2;
   localparam logic [2:0] ACT_STK_RELEASE = 3'd3;
   localparam logic [2:0] ACT_CLEAR       = 3'd4;
   localparam logic [2:0] ACT_FLUSH       = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]        action;
      logic signed [3:0] target;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic       key_valid;
      logic [3:0] key_id;
      logic       key_up;
      logic [3:0] pending_count;
      logic       bad_request;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_addr;
      logic [TIME_W-1:0]  wr_data;
      logic               rd_en;
      logic [ENTRY_W-1:0] rd_addr;
      logic               clr_all;
   } mem_req_type;

   // Key id of a stick code: -1 -> 8, +1 -> 9, -2 -> 10, +2 -> 11.
   function automatic logic [3:0] stick_id(input logic [2:0] code);
      logic mag_two;
      mag_two = (code == 3'b010) || (code == 3'b110);
      return STICK_ID_BASE + {2'b00, mag_two, ~code[2]};
   endfunction

endpackage

// File: sv/kmhr_time_ram.sv
`timescale 1ns / 1ps

// Press time store, one word per entry, with a valid bit per entry so that
// an entry never written since reset or clear reads as zero.
module kmhr_time_ram #(
   parameter int DEPTH = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kmhr_pkg::mem_req_type     mem_req,
   output logic [kmhr_pkg::TIME_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [kmhr_pkg::TIME_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            vld_ff, vld_in;
   logic [kmhr_pkg::TIME_W-1:0] rd_data_ff;
   logic                        rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (mem_req.clr_all) begin
         vld_in = '0;
      end
      if (mem_req.wr_en) begin
         vld_in[mem_req.wr_addr[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
         rd_vld_ff  <= vld_ff[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: sv/kmhr_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: walks the entries an item touches, reads each press time from
// the store, updates the key flags and queues the events, then plays the
// queue out one beat per cycle. A bad item skips the walk and plays out at once.
module kmhr_ctrl #(
   parameter int NUM_BUTTONS = 8,
   parameter int NUM_STICKS  = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  kmhr_pkg::req_type           req,
   input  logic [kmhr_pkg::TIME_W-1:0] min_hold,
   output kmhr_pkg::mem_req_type       mem_req,
   input  logic [kmhr_pkg::TIME_W-1:0] rd_data,
   output logic                        rsp_valid,
   output kmhr_pkg::rsp_type           rsp
);

   localparam int NE = NUM_BUTTONS + NUM_STICKS;
   localparam int EW = (NE > 1) ? $clog2(NE) : 1;
   localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int SW = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

   kmhr_pkg::state_type state_ff, state_in;

   logic [2:0]                  act_ff, act_in;
   logic [2:0]                  tgt_ff, tgt_in;
   logic [kmhr_pkg::TIME_W-1:0] now_ff, now_in;
   logic                        bad_ff, bad_in;
   logic [EW-1:0]               rd_idx_ff, rd_idx_in;
   logic [EW-1:0]               last_idx_ff, last_idx_in;
   logic                        issue_ff, issue_in;
   logic                        eval_vld_ff, eval_vld_in;
   logic [EW-1:0]               eval_idx_ff, eval_idx_in;
   logic [NUM_BUTTONS-1:0]      held_ff, held_in;
   logic [NE-1:0]               pend_ff, pend_in;
   logic [2:0]                  code_ff [NUM_STICKS];
   logic [2:0]                  code_in [NUM_STICKS];
   logic [3:0]                  q_id_ff [kmhr_pkg::RSP_MAX];
   logic [3:0]                  q_id_in [kmhr_pkg::RSP_MAX];
   logic                        q_up_ff [kmhr_pkg::RSP_MAX];
   logic                        q_up_in [kmhr_pkg::RSP_MAX];
   logic [kmhr_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [kmhr_pkg::CNT_W-1:0]  ptr_ff, ptr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   kmhr_pkg::rsp_type           rsp_ff, rsp_in;

   // Request decode.
   logic          accept;
   logic          bad_now;
   logic          is_sweep;
   logic [4:0]    mag;
   logic [EW-1:0] first_idx;

   // Entry under evaluation.
   logic                        is_stick;
   logic [BW-1:0]               b_idx;
   logic [SW-1:0]               s_idx;
   logic [kmhr_pkg::TIME_W-1:0] diff;
   logic                        too_soon;
   logic                        overdue;
   logic                        emit_last;

   // Up to two queue pushes per evaluated entry, first one first.
   logic                       p0_v, p0_up, p1_v, p1_up;
   logic [3:0]                 p0_id, p1_id;
   logic [kmhr_pkg::CNT_W-1:0] cnt_mid;

   assign accept   = start && (state_ff == kmhr_pkg::ST_IDLE);
   assign mag      = req.target[3] ? (5'd0 - {req.target[3], req.target})
                                   : {1'b0, req.target};
   assign is_sweep = (req.action == kmhr_pkg::ACT_CLEAR) ||
                     (req.action == kmhr_pkg::ACT_FLUSH);

   always_comb begin
      unique case (req.action) inside
         kmhr_pkg::ACT_BTN_PRESS, kmhr_pkg::ACT_BTN_RELEASE:
            bad_now = (req.target < 0) || (int'(req.target) >= NUM_BUTTONS);
         kmhr_pkg::ACT_STK_PRESS, kmhr_pkg::ACT_STK_RELEASE:
            bad_now = (mag == 5'd0) || (int'(mag) > NUM_STICKS);
         kmhr_pkg::ACT_CLEAR, kmhr_pkg::ACT_FLUSH:
            bad_now = 1'b0;
         default:
            bad_now = 1'b1;
      endcase
   end

   always_comb begin
      if (is_sweep) begin
         first_idx = '0;
      end else if ((req.action == kmhr_pkg::ACT_STK_PRESS) ||
                   (req.action == kmhr_pkg::ACT_STK_RELEASE)) begin
         first_idx = EW'(NUM_BUTTONS) + EW'(mag) - EW'(1);
      end else begin
         first_idx = EW'(req.target[2:0]);
      end
   end

   assign is_stick  = eval_idx_ff >= EW'(NUM_BUTTONS);
   assign b_idx     = eval_idx_ff[BW-1:0];
   assign s_idx     = SW'(eval_idx_ff - EW'(NUM_BUTTONS));
   assign diff      = now_ff - rd_data;
   assign too_soon  = diff < min_hold;
   assign overdue   = diff > min_hold;
   assign emit_last = (cnt_ff == '0) || (ptr_ff == cnt_ff - kmhr_pkg::CNT_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kmhr_pkg::ST_IDLE:
            if (start) begin
               state_in = bad_now ? kmhr_pkg::ST_EMIT : kmhr_pkg::ST_SWEEP;
            end
         kmhr_pkg::ST_SWEEP:
            if (eval_vld_ff && (eval_idx_ff == last_idx_ff)) begin
               state_in = kmhr_pkg::ST_EMIT;
            end
         kmhr_pkg::ST_EMIT:
            if (emit_last) begin
               state_in = kmhr_pkg::ST_IDLE;
            end
         default:
            state_in = kmhr_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine: handshake and store accesses.
   always_comb begin
      busy            = (state_ff != kmhr_pkg::ST_IDLE);
      mem_req.rd_en   = (state_ff == kmhr_pkg::ST_SWEEP) && issue_ff;
      mem_req.rd_addr = kmhr_pkg::ENTRY_W'(rd_idx_ff);
      mem_req.wr_en   = (state_ff == kmhr_pkg::ST_SWEEP) && eval_vld_ff &&
                        ((act_ff == kmhr_pkg::ACT_BTN_PRESS) ||
                         (act_ff == kmhr_pkg::ACT_STK_PRESS));
      mem_req.wr_addr = kmhr_pkg::ENTRY_W'(eval_idx_ff);
      mem_req.wr_data = now_ff;
      mem_req.clr_all = accept && (req.action == kmhr_pkg::ACT_CLEAR);
   end

   // Entry evaluation: flag updates and the events they cause.
   always_comb begin
      held_in = held_ff;
      pend_in = pend_ff;
      code_in = code_ff;
      p0_v  = 1'b0;
      p0_id = '0;
      p0_up = 1'b0;
      p1_v  = 1'b0;
      p1_id = '0;
      p1_up = 1'b0;
      if ((state_ff == kmhr_pkg::ST_SWEEP) && eval_vld_ff) begin
         unique case (act_ff)
            kmhr_pkg::ACT_BTN_PRESS: begin
               if (pend_ff[eval_idx_ff]) begin
                  p0_v  = 1'b1;
                  p0_id = 4'(b_idx);
                  p0_up = 1'b1;
                  pend_in[eval_idx_ff] = 1'b0;
               end
               held_in[b_idx] = 1'b1;
               p1_v  = 1'b1;
               p1_id = 4'(b_idx);
            end
            kmhr_pkg::ACT_BTN_RELEASE: begin
               if (too_soon) begin
                  pend_in[eval_idx_ff] = 1'b1;
               end else begin
                  held_in[b_idx] = 1'b0;
                  p0_v  = 1'b1;
                  p0_id = 4'(b_idx);
                  p0_up = 1'b1;
               end
            end
            kmhr_pkg::ACT_STK_PRESS: begin
               if (pend_ff[eval_idx_ff]) begin
                  p0_v  = (code_ff[s_idx] != 3'd0);
                  p0_id = kmhr_pkg::stick_id(code_ff[s_idx]);
                  p0_up = 1'b1;
                  pend_in[eval_idx_ff] = 1'b0;
               end
               code_in[s_idx] = tgt_ff;
               p1_v  = 1'b1;
               p1_id = kmhr_pkg::stick_id(tgt_ff);
            end
            kmhr_pkg::ACT_STK_RELEASE: begin
               if (too_soon) begin
                  pend_in[eval_idx_ff] = 1'b1;
               end else begin
                  code_in[s_idx] = 3'd0;
                  p0_v  = 1'b1;
                  p0_id = kmhr_pkg::stick_id(tgt_ff);
                  p0_up = 1'b1;
               end
            end
            kmhr_pkg::ACT_CLEAR: begin
               if (!is_stick) begin
                  p0_v  = held_ff[b_idx];
                  p0_id = 4'(b_idx);
                  held_in[b_idx] = 1'b0;
               end else begin
                  p0_v  = (code_ff[s_idx] != 3'd0);
                  p0_id = kmhr_pkg::stick_id(code_ff[s_idx]);
                  code_in[s_idx] = 3'd0;
               end
               p0_up = 1'b1;
               pend_in[eval_idx_ff] = 1'b0;
            end
            kmhr_pkg::ACT_FLUSH: begin
               if (pend_ff[eval_idx_ff] && overdue) begin
                  if (!is_stick) begin
                     p0_v  = 1'b1;
                     p0_id = 4'(b_idx);
                     held_in[b_idx] = 1'b0;
                  end else begin
                     p0_v  = (code_ff[s_idx] != 3'd0);
                     p0_id = kmhr_pkg::stick_id(code_ff[s_idx]);
                     code_in[s_idx] = 3'd0;
                  end
                  p0_up = 1'b1;
                  pend_in[eval_idx_ff] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Request capture, entry walk, event queue and result register.
   always_comb begin
      act_in       = act_ff;
      tgt_in       = tgt_ff;
      now_in       = now_ff;
      bad_in       = bad_ff;
      rd_idx_in    = rd_idx_ff;
      last_idx_in  = last_idx_ff;
      issue_in     = issue_ff;
      eval_vld_in  = 1'b0;
      eval_idx_in  = eval_idx_ff;
      q_id_in      = q_id_ff;
      q_up_in      = q_up_ff;
      cnt_in       = cnt_ff;
      cnt_mid      = cnt_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (accept) begin
         act_in      = req.action;
         tgt_in      = req.target[2:0];
         now_in      = req.now_time;
         bad_in      = bad_now;
         rd_idx_in   = first_idx;
         last_idx_in = is_sweep ? EW'(NE - 1) : first_idx;
         issue_in    = 1'b1;
         cnt_in      = '0;
         ptr_in      = '0;
      end

      if (state_ff == kmhr_pkg::ST_SWEEP) begin
         eval_vld_in = issue_ff;
         eval_idx_in = rd_idx_ff;
         if (issue_ff) begin
            if (rd_idx_ff == last_idx_ff) begin
               issue_in = 1'b0;
            end else begin
               rd_idx_in = rd_idx_ff + EW'(1);
            end
         end
         // Events past the result limit are dropped.
         if (p0_v && (cnt_ff < kmhr_pkg::CNT_W'(kmhr_pkg::RSP_MAX))) begin
            q_id_in[cnt_ff[kmhr_pkg::Q_W-1:0]] = p0_id;
            q_up_in[cnt_ff[kmhr_pkg::Q_W-1:0]] = p0_up;
            cnt_mid = cnt_ff + kmhr_pkg::CNT_W'(1);
         end
         cnt_in = cnt_mid;
         if (p1_v && (cnt_mid < kmhr_pkg::CNT_W'(kmhr_pkg::RSP_MAX))) begin
            q_id_in[cnt_mid[kmhr_pkg::Q_W-1:0]] = p1_id;
            q_up_in[cnt_mid[kmhr_pkg::Q_W-1:0]] = p1_up;
            cnt_in = cnt_mid + kmhr_pkg::CNT_W'(1);
         end
      end

      if (state_ff == kmhr_pkg::ST_EMIT) begin
         ptr_in        = ptr_ff + kmhr_pkg::CNT_W'(1);
         rsp_valid_in  = 1'b1;
         if (cnt_ff != '0) begin
            rsp_in.key_valid = 1'b1;
            rsp_in.key_id    = q_id_ff[ptr_ff[kmhr_pkg::Q_W-1:0]];
            rsp_in.key_up    = q_up_ff[ptr_ff[kmhr_pkg::Q_W-1:0]];
         end
         rsp_in.pending_count = 4'($countones(pend_ff));
         rsp_in.bad_request   = bad_ff;
         rsp_in.last          = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmhr_pkg::ST_IDLE;
         issue_ff     <= 1'b0;
         eval_vld_ff  <= 1'b0;
         held_ff      <= '0;
         pend_ff      <= '0;
         code_ff      <= '{default: 3'd0};
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         eval_vld_ff  <= eval_vld_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         code_ff      <= code_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      tgt_ff      <= tgt_in;
      now_ff      <= now_in;
      bad_ff      <= bad_in;
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      eval_idx_ff <= eval_idx_in;
      q_id_ff     <= q_id_in;
      q_up_ff     <= q_up_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/key_min_hold_release_scheduler.sv
`timescale 1ns / 1ps
// A button or stick item reads its entry from the time store and evaluates it, then registers its
// results out; clear and flush first walk every entry before their first result.
// A new item is taken once the last result of the previous one is registered. A single key gives
// one or two beats; a bad item skips the walk and gives one. The store reads one entry per cycle.
// Reset (synchronous) releases all keys at once, clears every flag and store valid bit and loads
// min_hold_time with 16600; there is no clearing pass. Result beats cannot be stalled.

`include "key_min_hold_release_scheduler_defines.svh"

module key_min_hold_release_scheduler #(
   parameter int NUM_BUTTONS = 8,
   parameter int NUM_STICKS  = 2
) (
   input  logic               clock,
   input  logic               reset,

   // Command channel: an item is taken when start is high and busy is low.
   input  logic               start,
   output logic               busy,
   input  kmhr_pkg::req_type  req_payload,

   // Result channel: one beat per cycle while rsp_valid is high.
   output logic               rsp_valid,
   output kmhr_pkg::rsp_type  rsp_payload,

   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Each button and each stick is one entry of the press time store. The
   // sticks follow the buttons, so clear and flush visit buttons first and
   // then sticks, which is the order in which their release events leave.
   localparam int NUM_ENTRIES = NUM_BUTTONS + NUM_STICKS;

   logic [kmhr_pkg::TIME_W-1:0] min_hold_ff, min_hold_in;
   logic                        csr_write;
   kmhr_pkg::mem_req_type       mem_req;
   logic [kmhr_pkg::TIME_W-1:0] mem_rd_data;

   // The only register, min_hold_time, sits at byte address 0. Writes to
   // the upper word are dropped and it reads back as zero.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == kmhr_pkg::REG_MIN_HOLD);

   always_comb begin
      min_hold_in = min_hold_ff;
      if (csr_write) begin
         min_hold_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_hold_ff <= kmhr_pkg::MIN_HOLD_RESET;
      end else begin
         min_hold_ff <= min_hold_in;
      end
   end

   assign prdata = (paddr[2] == kmhr_pkg::REG_MIN_HOLD) ? min_hold_ff : '0;

   // The sequencer walks the entries of an item and queues its events; the
   // store holds the press times, read one entry per cycle.
   kmhr_ctrl #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .NUM_STICKS  (NUM_STICKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_payload),
      .min_hold  (min_hold_ff),
      .mem_req   (mem_req),
      .rd_data   (mem_rd_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

   kmhr_time_ram #(
      .DEPTH (NUM_ENTRIES)
   ) u_time_ram (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // Results of one item leave back to back until the last beat.
   `KMHR_ASSERT(a_beats_contiguous, rsp_valid && !rsp_payload.last |=> rsp_valid, "result beats of one item were split")
   // An accepted item keeps the block busy and shows no beat right away.
   `KMHR_ASSERT(a_accept_busy, start && !busy |=> busy && !rsp_valid, "accepted item did not start processing")
   // After a reset edge the block is idle and silent.
   `KMHR_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_valid, "block not idle after reset")

endmodule
